FILE: rtl/core/next_permutation_engine_assert.svh
// Assertion macros for the next permutation engine.
// Used by the top level; each macro expands to one labeled concurrent assertion.
`ifndef NEXT_PERMUTATION_ENGINE_ASSERT_SVH
`define NEXT_PERMUTATION_ENGINE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NPE_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("npe assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define NPE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("npe assertion failed");

`endif

FILE: rtl/core/npe_pkg.sv
// Shared types and constants for the next permutation engine.
// No dependencies; the interfaces, the datapath, the controller and the top level import this package.
package npe_pkg;

  localparam int DATA_W      = 32;
  localparam int MAX_LEN_DEF = 64;

  // Datapath operations, one per controller step.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SCAN_PRIME,
    OP_SCAN,
    OP_FIND_PRIME,
    OP_FIND,
    OP_SWAP,
    OP_REV_RD,
    OP_REV_WR1,
    OP_REV_WR2,
    OP_EMIT_PRIME,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic in_last;    // element on the input is the final one
    logic rise;       // scan found the break point
    logic scan_end;   // scan reached the leftmost element
    logic hit;        // successor element found
    logic rev_more;   // reversal span not yet exhausted
    logic emit_last;  // element being emitted is the final one
  } dp_stat_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SCAN_PRIME,
    ST_SCAN,
    ST_FIND_PRIME,
    ST_FIND,
    ST_SWAP,
    ST_REV_RD,
    ST_REV_WR1,
    ST_REV_WR2,
    ST_EMIT_PRIME,
    ST_EMIT
  } ctrl_state_t;

endpackage

FILE: rtl/core/npe_stream_if.sv
// Valid/ready channel interfaces for element input and result output.
// Depends on npe_pkg for the data width.
interface npe_in_if import npe_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] element_value;
  logic                     element_last;

  modport source (output valid, output element_value, output element_last, input ready);
  modport sink   (input valid, input element_value, input element_last, output ready);
endinterface

interface npe_out_if import npe_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] result_value;
  logic                     result_last;
  logic                     wrapped;
  logic                     truncated;

  modport source (output valid, output result_value, output result_last,
                  output wrapped, output truncated, input ready);
  modport sink   (input valid, input result_value, input result_last,
                  input wrapped, input truncated, output ready);
endinterface

FILE: rtl/core/npe_datapath.sv
// Datapath: element memory, index counters, compare logic and output register.
// Depends on npe_pkg; driven by npe_ctrl through dp_cmd_t.
module npe_datapath import npe_pkg::*; #(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic signed [DATA_W-1:0] in_value,
  input  logic                     in_last,
  input  dp_cmd_t                  cmd,
  output dp_stat_t                 stat,
  output logic signed [DATA_W-1:0] out_value,
  output logic                     out_last,
  output logic                     out_wrapped,
  output logic                     out_truncated
);

  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CW = $clog2(MAX_LEN + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(MAX_LEN);
  localparam logic [AW-1:0] TOP_IDX  = AW'(MAX_LEN - 1);

  logic signed [DATA_W-1:0] mem [MAX_LEN];

  logic [CW-1:0] count_r, count_nxt;
  logic          ovf_r, ovf_nxt;
  logic [AW-1:0] last_idx_r, last_idx_nxt;
  logic [AW-1:0] cur_r, cur_nxt;
  logic [AW-1:0] lo_r, lo_nxt;
  logic [AW-1:0] hi_r, hi_nxt;
  logic [AW-1:0] bp_r, bp_nxt;
  logic signed [DATA_W-1:0] prev_r, prev_nxt;
  logic signed [DATA_W-1:0] pivot_r, pivot_nxt;
  logic signed [DATA_W-1:0] hold_r, hold_nxt;
  logic signed [DATA_W-1:0] rd_a_r, rd_b_r;
  logic          wrap_r, wrap_nxt;
  logic          trunc_r, trunc_nxt;
  logic signed [DATA_W-1:0] out_value_r, out_value_nxt;
  logic          out_last_r, out_last_nxt;
  logic          out_wrap_r, out_wrap_nxt;
  logic          out_trunc_r, out_trunc_nxt;

  logic                     we;
  logic [AW-1:0]            wa;
  logic signed [DATA_W-1:0] wd;
  logic                     rd_en;
  logic [AW-1:0]            ra, rb;
  logic                     full;

  assign full = (count_r == FULL_CNT);

  assign stat.in_last   = in_last;
  assign stat.rise      = (cur_r != last_idx_r) && (rd_a_r < prev_r);
  assign stat.scan_end  = (cur_r == '0);
  assign stat.hit       = (pivot_r < rd_a_r);
  assign stat.rev_more  = (lo_r < hi_r);
  assign stat.emit_last = (cur_r == last_idx_r);

  always_comb begin
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    last_idx_nxt  = last_idx_r;
    cur_nxt       = cur_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    bp_nxt        = bp_r;
    prev_nxt      = prev_r;
    pivot_nxt     = pivot_r;
    hold_nxt      = hold_r;
    wrap_nxt      = wrap_r;
    trunc_nxt     = trunc_r;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;
    out_wrap_nxt  = out_wrap_r;
    out_trunc_nxt = out_trunc_r;
    we            = 1'b0;
    wa            = cur_r;
    wd            = pivot_r;
    rd_en         = 1'b0;
    ra            = cur_r;
    rb            = hi_r;
    case (cmd.op)
      OP_LOAD: begin
        if (full) begin
          ovf_nxt = 1'b1;
        end else begin
          we        = 1'b1;
          wa        = count_r[AW-1:0];
          wd        = in_value;
          count_nxt = count_r + CW'(1);
        end
        if (in_last) begin
          last_idx_nxt = full ? TOP_IDX : count_r[AW-1:0];
          trunc_nxt    = ovf_r | full;
          count_nxt    = '0;
          ovf_nxt      = 1'b0;
        end
      end
      OP_SCAN_PRIME, OP_FIND_PRIME: begin
        rd_en   = 1'b1;
        ra      = last_idx_r;
        cur_nxt = last_idx_r;
      end
      OP_SCAN: begin
        prev_nxt = rd_a_r;
        if (stat.rise) begin
          bp_nxt    = cur_r;
          pivot_nxt = rd_a_r;
          wrap_nxt  = 1'b0;
        end else if (stat.scan_end) begin
          // no rise anywhere: reverse the whole sequence
          wrap_nxt = 1'b1;
          lo_nxt   = '0;
          hi_nxt   = last_idx_r;
        end else begin
          rd_en   = 1'b1;
          ra      = cur_r - AW'(1);
          cur_nxt = cur_r - AW'(1);
        end
      end
      OP_FIND: begin
        if (stat.hit) begin
          we       = 1'b1;
          wa       = cur_r;
          wd       = pivot_r;
          hold_nxt = rd_a_r;
        end else begin
          rd_en   = 1'b1;
          ra      = cur_r - AW'(1);
          cur_nxt = cur_r - AW'(1);
        end
      end
      OP_SWAP: begin
        we     = 1'b1;
        wa     = bp_r;
        wd     = hold_r;
        lo_nxt = bp_r + AW'(1);
        hi_nxt = last_idx_r;
      end
      OP_REV_RD: begin
        rd_en = 1'b1;
        ra    = lo_r;
        rb    = hi_r;
      end
      OP_REV_WR1: begin
        we = 1'b1;
        wa = lo_r;
        wd = rd_b_r;
      end
      OP_REV_WR2: begin
        we     = 1'b1;
        wa     = hi_r;
        wd     = rd_a_r;
        lo_nxt = lo_r + AW'(1);
        hi_nxt = hi_r - AW'(1);
      end
      OP_EMIT_PRIME: begin
        rd_en   = 1'b1;
        ra      = '0;
        cur_nxt = '0;
      end
      OP_EMIT: begin
        out_value_nxt = rd_a_r;
        out_last_nxt  = stat.emit_last;
        out_wrap_nxt  = wrap_r;
        out_trunc_nxt = trunc_r;
        if (!stat.emit_last) begin
          rd_en   = 1'b1;
          ra      = cur_r + AW'(1);
          cur_nxt = cur_r + AW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // element memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en) begin
      rd_a_r <= mem[ra];
      rd_b_r <= mem[rb];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_idx_r  <= last_idx_nxt;
    cur_r       <= cur_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    bp_r        <= bp_nxt;
    prev_r      <= prev_nxt;
    pivot_r     <= pivot_nxt;
    hold_r      <= hold_nxt;
    wrap_r      <= wrap_nxt;
    trunc_r     <= trunc_nxt;
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
    out_wrap_r  <= out_wrap_nxt;
    out_trunc_r <= out_trunc_nxt;
  end

  assign out_value     = out_value_r;
  assign out_last      = out_last_r;
  assign out_wrapped   = out_wrap_r;
  assign out_truncated = out_trunc_r;

endmodule

FILE: rtl/core/npe_ctrl.sv
// Controller state machine: sequences load, scan, swap, reverse and emit.
// Depends on npe_pkg; drives npe_datapath through dp_cmd_t.
module npe_ctrl import npe_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        slot_free;

  // output register can take a new result this cycle
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD: begin
        if (in_valid && stat.in_last) begin
          state_nxt = ST_SCAN_PRIME;
        end
      end
      ST_SCAN_PRIME: state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (stat.rise) begin
          state_nxt = ST_FIND_PRIME;
        end else if (stat.scan_end) begin
          state_nxt = ST_REV_RD;
        end
      end
      ST_FIND_PRIME: state_nxt = ST_FIND;
      ST_FIND: begin
        if (stat.hit) begin
          state_nxt = ST_SWAP;
        end
      end
      ST_SWAP: state_nxt = ST_REV_RD;
      ST_REV_RD: begin
        state_nxt = stat.rev_more ? ST_REV_WR1 : ST_EMIT_PRIME;
      end
      ST_REV_WR1: state_nxt = ST_REV_WR2;
      ST_REV_WR2: state_nxt = ST_REV_RD;
      ST_EMIT_PRIME: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (slot_free && stat.emit_last) begin
          state_nxt = ST_LOAD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd.op   = OP_NONE;
    case (state_r)
      ST_LOAD: begin
        in_ready = 1'b1;
        cmd.op   = in_valid ? OP_LOAD : OP_NONE;
      end
      ST_SCAN_PRIME: cmd.op = OP_SCAN_PRIME;
      ST_SCAN:       cmd.op = OP_SCAN;
      ST_FIND_PRIME: cmd.op = OP_FIND_PRIME;
      ST_FIND:       cmd.op = OP_FIND;
      ST_SWAP:       cmd.op = OP_SWAP;
      ST_REV_RD:     cmd.op = OP_REV_RD;
      ST_REV_WR1:    cmd.op = OP_REV_WR1;
      ST_REV_WR2:    cmd.op = OP_REV_WR2;
      ST_EMIT_PRIME: cmd.op = OP_EMIT_PRIME;
      ST_EMIT:       cmd.op = slot_free ? OP_EMIT : OP_NONE;
      default:       cmd.op = OP_NONE;
    endcase
  end

  always_comb begin
    if (cmd.op == OP_EMIT) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

FILE: rtl/core/next_permutation_engine.sv
// Next lexicographic permutation engine: loads a sequence of signed 32-bit
// elements, one per transfer, and on the element marked last emits the next
// greater arrangement, one transfer per element. The input side accepts one
// element per cycle while loading; after the last element the block is busy
// and holds in_ch.ready low while it works on its element memory, which has
// one write port and two registered read ports. After the last transfer the
// block scans back from the end for the break point; if it finds one, it
// searches for the successor and swaps it in. It then reverses the tail, or
// the whole sequence when there is no break point, with a read step and two
// write steps per swapped pair, paced by the single memory write port. A
// prime step follows, then the results, which wait while out_ch.ready is
// low. Results leave through an output register, so loading of the next
// sequence starts while the final result still waits to be taken. Elements
// beyond MAX_LEN are dropped and flag truncated on every result; a sequence
// with no rise comes out ascending with wrapped set on every result. The
// memory needs no clearing after reset: only entries of the current sequence
// are ever read.
// Depends on npe_pkg, npe_stream_if, npe_ctrl, npe_datapath and the assertion macros.
`include "next_permutation_engine_assert.svh"

module next_permutation_engine import npe_pkg::*; #(
  parameter int MAX_LEN = MAX_LEN_DEF   // sequence store depth, 1 to 64
) (
  input  logic      clk,
  input  logic      rst_n,
  npe_in_if.sink    in_ch,
  npe_out_if.source out_ch
);

  dp_cmd_t  cmd;    // controller -> datapath operation
  dp_stat_t stat;   // datapath compare results back to the controller

  // Sequencer: walks the load / scan / find / swap / reverse / emit steps.
  npe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Element memory, indices, compares and the result register.
  npe_datapath #(
    .MAX_LEN (MAX_LEN)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_value      (in_ch.element_value),
    .in_last       (in_ch.element_last),
    .cmd           (cmd),
    .stat          (stat),
    .out_value     (out_ch.result_value),
    .out_last      (out_ch.result_last),
    .out_wrapped   (out_ch.wrapped),
    .out_truncated (out_ch.truncated)
  );

  // An input transfer always turns into a load operation.
  `NPE_ASSERT_IMPLY(a_in_xfer_loads, clk, rst_n, in_ch.valid && in_ch.ready, cmd.op == OP_LOAD)
  // A result is only loaded when the output register is free or draining.
  `NPE_ASSERT_IMPLY(a_emit_slot_free, clk, rst_n, cmd.op == OP_EMIT, !out_ch.valid || out_ch.ready)
  // A loaded result is presented in the following cycle.
  `NPE_ASSERT_NEXT(a_emit_shows, clk, rst_n, cmd.op == OP_EMIT, out_ch.valid)
  // After the final result is loaded, loading of the next sequence reopens.
  `NPE_ASSERT_NEXT(a_done_reopens, clk, rst_n, cmd.op == OP_EMIT && stat.emit_last, in_ch.ready)

endmodule
